// File: sv/call_site_profile_accumulator_defines.svh
// Assertion macros for the call-site profile accumulator.
// Included by the top level; no other dependencies.
`ifndef CALL_SITE_PROFILE_ACCUMULATOR_DEFINES_SVH
`define CALL_SITE_PROFILE_ACCUMULATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Check a consequence in the same cycle as its trigger
`define CSPA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cspa: same-cycle check failed");

// Check a consequence in the cycle after its trigger
`define CSPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cspa: next-cycle check failed");

`else

`define CSPA_ASSERT_SAME(label, clk, rst, ante, cons)
`define CSPA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: sv/cspa_pkg.sv
// Shared types and constants for the call-site profile accumulator.
// No dependencies; imported by every module of the block.
`default_nettype none

package cspa_pkg;

   // Default sizing
   localparam int DEF_TABLE_DEPTH = 256;
   localparam int DEF_COUNT_BITS  = 32;

   // Stream widths
   localparam int REQ_DATA_W = 304;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 504;
   localparam int RSP_USER_W = 3;
   localparam int FILL_OUT_W = 17;

   // Item kinds; mode one is a local-only add, any mode with the high bit set clears
   localparam logic [1:0] MODE_FULL  = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   typedef enum logic [2:0] {
      ST_NEW      = 3'd0,
      ST_ACCUM    = 3'd1,
      ST_RANGE    = 3'd2,
      ST_MISMATCH = 3'd3,
      ST_CLEARED  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_INIT_WIPE,
      S_IDLE,
      S_CLR_WIPE,
      S_CALC
   } ctrl_state_type;

   // Input payload, last field in the lowest bits
   typedef struct packed {
      logic [63:0] local_span_in;
      logic [63:0] local_work_in;
      logic [63:0] span_in;
      logic [63:0] work_in;
      logic [31:0] site_id;
      logic [15:0] slot;
   } req_data_type;

   typedef struct packed {
      logic       top_flag;
      logic [1:0] mode;
   } req_user_type;

   // Result payload, last field in the lowest bits, padded to whole bytes
   typedef struct packed {
      logic [6:0]  pad;
      logic [31:0] local_count_total;
      logic [63:0] local_span_total;
      logic [63:0] local_work_total;
      logic [31:0] top_count_total;
      logic [63:0] top_span_total;
      logic [63:0] top_work_total;
      logic [31:0] count_total;
      logic [63:0] span_total;
      logic [63:0] work_total;
      logic [16:0] filled_count;
   } rsp_data_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic wipe_step;
      logic commit;
   } cspa_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_req;
      logic wipe_last;
      logic rsp_free;
   } cspa_status_type;

endpackage

`default_nettype wire

// File: sv/cspa_ctrl.sv
// Sequencing state machine of the call-site profile accumulator.
// Depends on cspa_pkg; drives the datapath through cspa_cmd_type.
`default_nettype none

module cspa_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  cspa_pkg::cspa_status_type  status,
   output cspa_pkg::cspa_cmd_type     cmd
);
   import cspa_pkg::*;

   ctrl_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT_WIPE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      req_tready    = 1'b0;
      cmd.capture   = 1'b0;
      cmd.wipe_step = 1'b0;
      cmd.commit    = 1'b0;
      unique case (state_ff)
         S_INIT_WIPE: begin
            cmd.wipe_step = 1'b1;
            if (status.wipe_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = status.clear_req ? S_CLR_WIPE : S_CALC;
            end
         end
         S_CLR_WIPE: begin
            cmd.wipe_step = 1'b1;
            if (status.wipe_last) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            // hold until the result register can take the new transfer
            if (status.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT_WIPE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: sv/cspa_datapath.sv
// Record table, update adders and result register of the call-site profile accumulator.
// Depends on cspa_pkg; steered by cspa_ctrl through cspa_cmd_type.
`default_nettype none

module cspa_datapath #(
   parameter int TABLE_DEPTH = cspa_pkg::DEF_TABLE_DEPTH,
   parameter int COUNT_BITS  = cspa_pkg::DEF_COUNT_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cspa_pkg::cspa_cmd_type            cmd,
   output cspa_pkg::cspa_status_type         status,
   input  logic [cspa_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [cspa_pkg::REQ_USER_W-1:0]   req_tuser,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [cspa_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [cspa_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import cspa_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

   typedef struct packed {
      logic                  valid;
      logic [31:0]           site;
      logic [63:0]           work;
      logic [63:0]           span;
      logic [COUNT_BITS-1:0] count;
      logic [63:0]           root_work;
      logic [63:0]           root_span;
      logic [COUNT_BITS-1:0] root_count;
      logic [63:0]           own_work;
      logic [63:0]           own_span;
      logic [COUNT_BITS-1:0] own_count;
   } row_type;

   row_type               mem [TABLE_DEPTH];
   row_type               rd_row_ff;
   row_type               base_row;
   row_type               new_row;
   req_data_type          req_data;
   req_user_type          req_user;
   req_data_type          item_ff;
   req_user_type          item_user_ff;
   logic                  in_range_ff;
   logic [ADDR_W-1:0]     req_idx;
   logic [ADDR_W-1:0]     item_idx;
   logic [ADDR_W-1:0]     wipe_ptr_ff, wipe_ptr_in;
   logic [FILL_W-1:0]     filled_ff, filled_in;
   logic [FILL_W-1:0]     filled_after;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_data_type          rsp_data_ff, rsp_data_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic                  req_clear;
   logic                  item_clear;
   logic                  item_full;
   logic                  item_top;
   logic                  fresh;
   logic                  site_match;
   logic                  write_en;
   logic                  show;

   // Unpack the incoming transfer
   assign req_data  = req_data_type'(req_tdata);
   assign req_user  = req_user_type'(req_tuser);
   assign req_idx   = req_data.slot[ADDR_W-1:0];
   assign req_clear = (req_user.mode >= MODE_CLEAR);

   assign item_idx   = item_ff.slot[ADDR_W-1:0];
   assign item_clear = (item_user_ff.mode >= MODE_CLEAR);
   assign item_full  = (item_user_ff.mode == MODE_FULL);
   assign item_top   = item_full && item_user_ff.top_flag;
   assign fresh      = !rd_row_ff.valid;
   assign site_match = (rd_row_ff.site == item_ff.site_id);

   // Start from an empty record when the slot is not yet filled
   assign base_row = fresh ? '0 : rd_row_ff;

   // Accumulate the record; full and top totals only when the item asks for them
   always_comb begin
      new_row.valid      = 1'b1;
      new_row.site       = item_ff.site_id;
      new_row.work       = base_row.work + (item_full ? item_ff.work_in : 64'd0);
      new_row.span       = base_row.span + (item_full ? item_ff.span_in : 64'd0);
      new_row.count      = base_row.count + COUNT_BITS'(item_full);
      new_row.root_work  = base_row.root_work + (item_top ? item_ff.work_in : 64'd0);
      new_row.root_span  = base_row.root_span + (item_top ? item_ff.span_in : 64'd0);
      new_row.root_count = base_row.root_count + COUNT_BITS'(item_top);
      new_row.own_work   = base_row.own_work + item_ff.local_work_in;
      new_row.own_span   = base_row.own_span + item_ff.local_span_in;
      new_row.own_count  = base_row.own_count + COUNT_BITS'(1'b1);
   end

   // Decide the outcome of the held item
   always_comb begin
      rsp_status_in = ST_CLEARED;
      write_en      = 1'b0;
      show          = 1'b0;
      if (item_clear) begin
         rsp_status_in = ST_CLEARED;
      end else if (!in_range_ff) begin
         rsp_status_in = ST_RANGE;
      end else if (fresh) begin
         rsp_status_in = ST_NEW;
         write_en      = 1'b1;
         show          = 1'b1;
      end else if (!site_match) begin
         rsp_status_in = ST_MISMATCH;
      end else begin
         rsp_status_in = ST_ACCUM;
         write_en      = 1'b1;
         show          = 1'b1;
      end
   end

   assign filled_after = (write_en && fresh) ? filled_ff + FILL_W'(1) : filled_ff;

   // Build the result; totals stay zero for dropped and clear items
   always_comb begin
      rsp_data_in              = '0;
      rsp_data_in.filled_count = FILL_OUT_W'(filled_after);
      if (show) begin
         rsp_data_in.work_total        = new_row.work;
         rsp_data_in.span_total        = new_row.span;
         rsp_data_in.count_total       = 32'(new_row.count);
         rsp_data_in.top_work_total    = new_row.root_work;
         rsp_data_in.top_span_total    = new_row.root_span;
         rsp_data_in.top_count_total   = 32'(new_row.root_count);
         rsp_data_in.local_work_total  = new_row.own_work;
         rsp_data_in.local_span_total  = new_row.own_span;
         rsp_data_in.local_count_total = 32'(new_row.own_count);
      end
   end

   // Control register next values
   always_comb begin
      wipe_ptr_in = wipe_ptr_ff;
      if (cmd.capture && req_clear) begin
         wipe_ptr_in = '0;
      end else if (cmd.wipe_step) begin
         wipe_ptr_in = status.wipe_last ? '0 : wipe_ptr_ff + ADDR_W'(1);
      end

      filled_in = filled_ff;
      if (cmd.capture && req_clear) begin
         filled_in = '0;
      end else if (cmd.commit) begin
         filled_in = filled_after;
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wipe_ptr_ff  <= '0;
         filled_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wipe_ptr_ff  <= wipe_ptr_in;
         filled_ff    <= filled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Record table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wipe_step) begin
         mem[wipe_ptr_ff] <= '0;
      end else if (cmd.commit && write_en) begin
         mem[item_idx] <= new_row;
      end
      if (cmd.capture) begin
         rd_row_ff <= mem[req_idx];
      end
   end

   // Hold the item and the result
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff      <= req_data;
         item_user_ff <= req_user;
         in_range_ff  <= ({1'b0, req_data.slot} < 17'(TABLE_DEPTH));
      end
      if (cmd.commit) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign status.clear_req = req_clear;
   assign status.wipe_last = (wipe_ptr_ff == ADDR_W'(TABLE_DEPTH - 1));
   assign status.rsp_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

// File: sv/call_site_profile_accumulator.sv
// Top level of the call-site profile accumulator: controller, datapath and checks.
// Depends on cspa_pkg, cspa_ctrl, cspa_datapath and the assertion macro header.
//
// A direct-indexed table of TABLE_DEPTH profiling records, one per call-site slot, each
// holding a call-site id and nine wrapping totals. Every request transfer gives exactly one
// response transfer carrying the status code, the filled-entry count and the record's new
// totals. An add goes from acceptance to a loaded result through the registered table read
// and then the update adders and the write back, which wait while the output register still
// holds an untaken response; the next add is taken only once this one is committed. A clear
// sweeps the table one row per cycle. After reset the same sweep runs with req_tready low
// before the first request is taken. A new request is accepted while the previous response
// still waits in the output register.
`default_nettype none
`include "call_site_profile_accumulator_defines.svh"

module call_site_profile_accumulator #(
   parameter int TABLE_DEPTH = cspa_pkg::DEF_TABLE_DEPTH,
   parameter int COUNT_BITS  = cspa_pkg::DEF_COUNT_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // slot, site_id, work_in, span_in, local_work_in, local_span_in
   input  logic [cspa_pkg::REQ_DATA_W-1:0]   req_tdata,
   // mode, top_flag
   input  logic [cspa_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // filled_count, work_total, span_total, count_total, top_work_total, top_span_total,
   // top_count_total, local_work_total, local_span_total, local_count_total, zero pad
   output logic [cspa_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status
   output logic [cspa_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import cspa_pkg::*;

   cspa_cmd_type    cmd;
   cspa_status_type status;

   cspa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cspa_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .COUNT_BITS  (COUNT_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Only one item in flight: ready drops right after an accepted transfer
   `CSPA_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)

   // Never overwrite a response that has not been taken
   `CSPA_ASSERT_SAME(a_commit_free, clock, reset, cmd.commit, status.rsp_free)

   // A response appears only after a commit
   `CSPA_ASSERT_SAME(a_rsp_from_commit, clock, reset, $rose(rsp_tvalid), $past(cmd.commit))

   // The filled count never exceeds the table
   `CSPA_ASSERT_SAME(a_fill_bound, clock, reset, rsp_tvalid, rsp_tdata[16:0] <= 17'(TABLE_DEPTH))

endmodule

`default_nettype wire
